// File: sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// antecedent and consequent in the same cycle
`define SBPR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// consequent in the cycle after the antecedent
`define SBPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: sv/sbpr_pkg.sv
// package: types, codes and constants of the servo bus packet responder
`default_nettype none
package sbpr_pkg;
  localparam int FRAME_BYTES_DEF    = 64;
  localparam int MAX_READ_BYTES_DEF = 8;

  localparam logic [7:0] HDR_BYTE      = 8'hFF;
  localparam logic [7:0] BCAST_ID      = 8'hFE;
  localparam logic [7:0] ID_MAX        = 8'd253;
  localparam logic [7:0] START_ID_RST  = 8'd1;
  localparam logic [7:0] GAP_LIMIT_RST = 8'd10;

  localparam logic [7:0] INS_PING  = 8'd1;
  localparam logic [7:0] INS_READ  = 8'd2;
  localparam logic [7:0] INS_WRITE = 8'd3;

  localparam logic [7:0] REG_ID     = 8'd5;
  localparam logic [7:0] REG_TORQUE = 8'd40;
  localparam logic [7:0] REG_GOAL   = 8'd42;
  localparam logic [7:0] REG_POS    = 8'd56;
  localparam logic [7:0] REG_SPEED  = 8'd58;
  localparam logic [7:0] REG_LOAD   = 8'd60;
  localparam logic [7:0] REG_VOLT   = 8'd62;
  localparam logic [7:0] REG_TEMP   = 8'd63;

  // frame offsets fetched for decode
  localparam logic [7:0] PAR_FIRST = 8'd2;
  localparam logic [7:0] PAR_LAST  = 8'd11;
  localparam int         PAR_N     = 10;
  // status packet: header, header, id, length, error
  localparam logic [7:0] STAT_HDR_N = 8'd5;

  typedef enum logic [0:0] {CFG_START_ID, CFG_GAP_LIMIT} cfg_idx_t;
  typedef enum logic [1:0] {K_TX, K_GOAL, K_TORQUE, K_ID} kind_t;
  typedef enum logic [1:0] {RT_NONE, RT_SUM, RT_CHK, RT_PAR} rd_tag_t;
  typedef enum logic [2:0] {
    RS_ZERO, RS_BLOCK, RS_POS, RS_SPEED, RS_LOAD, RS_VOLT, RS_TEMP, RS_ID
  } rsel_t;
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SUM, S_CHK, S_FETCH, S_WAIT, S_DECIDE, S_EVENT, S_STAT
  } state_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  rx_byte;
    logic [31:0] time_ms;
    logic [15:0] position;
    logic [15:0] velocity;
    logic [15:0] load_value;
    logic [7:0]  voltage;
    logic [7:0]  temperature;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         tx_byte;
    logic               last;
    logic signed [15:0] goal_position;
    logic [15:0]        goal_time;
    logic [15:0]        goal_speed;
    logic               torque_on;
    logic [7:0]         new_id;
  } out_item_t;

  typedef struct packed {
    logic       rd_en;
    rd_tag_t    rd_tag;
    logic [7:0] rd_addr;
    logic       clr_sum;
    logic       plan_latch;
    logic       emit_event;
    logic       emit_byte;
    logic [7:0] byte_idx;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic       frame_done;
    logic [7:0] len;
    logic       plan_go;
    logic       has_event;
    logic       reply;
    logic [7:0] dlen;
    logic       out_free;
  } sts_t;
endpackage
`default_nettype wire

// File: sv/sbpr_ctrl.sv
// controller: sequences frame check, decode and result emission
`default_nettype none
module sbpr_ctrl import sbpr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t     state_r, state_nxt;
  logic [7:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.frame_done) begin
          cnt_nxt     = PAR_FIRST;
          cmd.clr_sum = 1'b1;
          state_nxt   = S_SUM;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SUM: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_tag  = RT_SUM;
        cmd.rd_addr = cnt_r;
        if (cnt_r == 8'(sts.len + 8'd2)) state_nxt = S_CHK;
        else cnt_nxt = 8'(cnt_r + 8'd1);
      end
      S_CHK: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_tag  = RT_CHK;
        cmd.rd_addr = 8'(sts.len + 8'd3);
        cnt_nxt     = PAR_FIRST;
        state_nxt   = S_FETCH;
      end
      S_FETCH: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_tag  = RT_PAR;
        cmd.rd_addr = cnt_r;
        if (cnt_r == PAR_LAST) state_nxt = S_WAIT;
        else cnt_nxt = 8'(cnt_r + 8'd1);
      end
      S_WAIT: state_nxt = S_DECIDE;
      S_DECIDE: begin
        cmd.plan_latch = 1'b1;
        state_nxt      = sts.plan_go ? S_EVENT : S_IDLE;
      end
      S_EVENT: begin
        if (!sts.has_event) begin
          cnt_nxt   = '0;
          state_nxt = S_STAT;
        end else if (sts.out_free) begin
          cmd.emit_event = 1'b1;
          cmd.last       = !sts.reply;
          cnt_nxt        = '0;
          state_nxt      = sts.reply ? S_STAT : S_IDLE;
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.emit_byte = 1'b1;
          cmd.byte_idx  = cnt_r;
          if (cnt_r == 8'(sts.dlen + STAT_HDR_N)) begin
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = 8'(cnt_r + 8'd1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: sv/sbpr_dp.sv
// datapath: frame store, framing, decode, telemetry and result register
`default_nettype none
module sbpr_dp import sbpr_pkg::*; #(
  parameter int FRAME_BYTES    = FRAME_BYTES_DEF,
  parameter int MAX_READ_BYTES = MAX_READ_BYTES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_fire,
  input  wire in_item_t  in_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire cmd_t      cmd,
  output sts_t           sts,
  input  wire logic      out_stall,
  output logic           out_valid,
  output out_item_t      out_data
);
  localparam int AW = $clog2(FRAME_BYTES);

  logic [7:0]    mem [FRAME_BYTES];
  logic [FRAME_BYTES-1:0] vld_r;
  logic [AW-1:0] idx_r, idx_nxt, idx0;
  logic [AW:0]   inc;
  logic [7:0]    len_r, lenv;
  logic [31:0]   last_r;
  logic          done_r, done_nxt, wr_en, over;
  logic [7:0]    cur_id_r, gap_r;
  logic [15:0]   pos_r, spd_r, load_r;
  logic [7:0]    volt_r, temp_r;

  logic [7:0]    rdata_r, rd;
  logic          rvld_r;
  rd_tag_t       tag_r;
  logic [3:0]    raddr_r;
  logic [7:0]    sum_r, tsum_r;
  logic          chk_ok_r;
  logic [7:0]    par_r [PAR_N];

  logic          p_go, p_ev, p_reply;
  kind_t         p_evk;
  logic [7:0]    p_dl;
  rsel_t         p_rsel;
  logic          ev_r, reply_r;
  kind_t         evk_r;
  logic [7:0]    dl_r;
  rsel_t         rsel_r;

  logic [7:0]    j, dbyte, tx;
  out_item_t     ev_item;
  out_item_t     out_r, out_nxt;
  logic          out_valid_r, out_free;

  // framing
  always_comb begin
    over     = (32'(in_data.time_ms - last_r) > {24'd0, gap_r});
    idx0     = (idx_r != '0 && over) ? '0 : idx_r;
    wr_en    = 1'b0;
    done_nxt = 1'b0;
    idx_nxt  = idx0;
    inc      = (AW+1)'(idx0) + (AW+1)'(1);
    lenv     = (idx0 == AW'(3)) ? in_data.rx_byte : len_r;
    if ((idx0 == '0 || idx0 == AW'(1)) && in_data.rx_byte != HDR_BYTE) begin
      idx_nxt = '0;
    end else begin
      wr_en = 1'b1;
      if (inc > (AW+1)'(3) && (9'(lenv) + 9'd4) == 9'(inc)) begin
        done_nxt = 1'b1;
        idx_nxt  = '0;
      end else if (inc == (AW+1)'(FRAME_BYTES)) begin
        idx_nxt = '0;
      end else begin
        idx_nxt = inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      last_r <= '0;
      done_r <= 1'b0;
      vld_r  <= '0;
      len_r  <= '0;
    end else if (in_fire) begin
      done_r <= !in_data.operation && done_nxt;
      if (!in_data.operation) begin
        last_r <= in_data.time_ms;
        idx_r  <= idx_nxt;
        if (wr_en) begin
          vld_r[idx0] <= 1'b1;
          if (idx0 == AW'(3)) len_r <= in_data.rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !in_data.operation && wr_en) mem[idx0] <= in_data.rx_byte;
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.rd_addr[AW-1:0]];
      rvld_r  <= vld_r[cmd.rd_addr[AW-1:0]];
      raddr_r <= cmd.rd_addr[3:0];
    end
  end

  assign rd = rvld_r ? rdata_r : 8'h00;

  // config, telemetry and node id
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_id_r <= START_ID_RST;
      gap_r    <= GAP_LIMIT_RST;
      pos_r    <= '0;
      spd_r    <= '0;
      load_r   <= '0;
      volt_r   <= '0;
      temp_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_START_ID:  cur_id_r <= cfg_wdata;
          CFG_GAP_LIMIT: gap_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.emit_event && evk_r == K_ID) cur_id_r <= par_r[4];
      if (in_fire && in_data.operation) begin
        pos_r  <= in_data.position;
        spd_r  <= in_data.velocity;
        load_r <= in_data.load_value;
        volt_r <= in_data.voltage;
        temp_r <= in_data.temperature;
      end
    end
  end

  // read return handling
  always_ff @(posedge clk) begin
    if (!rst_n) tag_r <= RT_NONE;
    else tag_r <= cmd.rd_en ? cmd.rd_tag : RT_NONE;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_sum) sum_r <= '0;
    else if (tag_r == RT_SUM) sum_r <= 8'(sum_r + rd);
    if (tag_r == RT_CHK) chk_ok_r <= ((~sum_r) == rd);
    if (tag_r == RT_PAR) par_r[4'(raddr_r - 4'd2)] <= rd;
  end

  // decode
  always_comb begin
    logic match, bc;
    bc      = (par_r[0] == BCAST_ID);
    match   = chk_ok_r && (par_r[0] == cur_id_r || bc);
    p_go    = 1'b0;
    p_ev    = 1'b0;
    p_evk   = K_TX;
    p_reply = 1'b0;
    p_dl    = '0;
    p_rsel  = RS_ZERO;
    if (match) begin
      priority if (par_r[2] == INS_PING) begin
        p_reply = 1'b1;
      end else if (par_r[2] == INS_READ && len_r >= 8'd4) begin
        p_reply = !bc;
        priority if (par_r[3] == REG_POS && par_r[4] >= 8'd8) begin
          p_rsel = RS_BLOCK; p_dl = 8'd8;
        end else if (par_r[3] == REG_POS && par_r[4] >= 8'd2) begin
          p_rsel = RS_POS; p_dl = 8'd2;
        end else if (par_r[3] == REG_SPEED && par_r[4] >= 8'd2) begin
          p_rsel = RS_SPEED; p_dl = 8'd2;
        end else if (par_r[3] == REG_LOAD && par_r[4] >= 8'd2) begin
          p_rsel = RS_LOAD; p_dl = 8'd2;
        end else if (par_r[3] == REG_VOLT) begin
          p_rsel = RS_VOLT; p_dl = 8'd1;
        end else if (par_r[3] == REG_TEMP) begin
          p_rsel = RS_TEMP; p_dl = 8'd1;
        end else if (par_r[3] == REG_ID) begin
          p_rsel = RS_ID; p_dl = 8'd1;
        end else begin
          p_dl = (par_r[4] > 8'(MAX_READ_BYTES)) ? 8'(MAX_READ_BYTES) : par_r[4];
        end
      end else if (par_r[2] == INS_WRITE && len_r >= 8'd3) begin
        p_reply = !bc;
        priority if (par_r[3] == REG_GOAL) begin
          p_ev = 1'b1; p_evk = K_GOAL;
        end else if (par_r[3] == REG_TORQUE) begin
          p_ev = 1'b1; p_evk = K_TORQUE;
        end else if (par_r[3] == REG_ID && par_r[4] != 8'd0 && par_r[4] <= ID_MAX) begin
          p_ev = 1'b1; p_evk = K_ID;
        end else begin
          p_ev = 1'b0;
        end
      end else begin
        p_reply = 1'b0;
      end
    end
    p_go = p_ev || p_reply;
  end

  always_ff @(posedge clk) begin
    if (cmd.plan_latch) begin
      ev_r    <= p_ev;
      evk_r   <= p_evk;
      reply_r <= p_reply;
      dl_r    <= p_dl;
      rsel_r  <= p_rsel;
    end
  end

  // status packet bytes
  assign j = 8'(cmd.byte_idx - STAT_HDR_N);

  always_comb begin
    unique case (rsel_r)
      RS_BLOCK: begin
        unique case (j[2:0])
          3'd0: dbyte = pos_r[15:8];
          3'd1: dbyte = pos_r[7:0];
          3'd2: dbyte = spd_r[15:8];
          3'd3: dbyte = spd_r[7:0];
          3'd4: dbyte = load_r[15:8];
          3'd5: dbyte = load_r[7:0];
          3'd6: dbyte = volt_r;
          default: dbyte = temp_r;
        endcase
      end
      RS_POS:   dbyte = j[0] ? pos_r[7:0]  : pos_r[15:8];
      RS_SPEED: dbyte = j[0] ? spd_r[7:0]  : spd_r[15:8];
      RS_LOAD:  dbyte = j[0] ? load_r[7:0] : load_r[15:8];
      RS_VOLT:  dbyte = volt_r;
      RS_TEMP:  dbyte = temp_r;
      RS_ID:    dbyte = cur_id_r;
      default:  dbyte = 8'h00;
    endcase
  end

  always_comb begin
    priority if (cmd.byte_idx < 8'd2) tx = HDR_BYTE;
    else if (cmd.byte_idx == 8'd2) tx = cur_id_r;
    else if (cmd.byte_idx == 8'd3) tx = 8'(dl_r + 8'd2);
    else if (cmd.byte_idx == 8'd4) tx = 8'h00;
    else if (cmd.byte_idx == 8'(dl_r + STAT_HDR_N)) tx = ~tsum_r;
    else tx = dbyte;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) tsum_r <= (cmd.byte_idx < 8'd2) ? 8'h00 : 8'(tsum_r + tx);
  end

  always_comb begin
    ev_item      = '0;
    ev_item.kind = evk_r;
    unique case (evk_r)
      K_GOAL: begin
        ev_item.goal_position = {par_r[4], par_r[5]};
        ev_item.goal_time     = (len_r >= 8'd6) ? {par_r[6], par_r[7]} : 16'd0;
        ev_item.goal_speed    = (len_r >= 8'd8) ? {par_r[8], par_r[9]} : 16'd0;
      end
      K_TORQUE: ev_item.torque_on = (par_r[4] != 8'd0);
      K_ID:     ev_item.new_id    = par_r[4];
      default: ;
    endcase
  end

  // result register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit_event || cmd.emit_byte) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.emit_event) begin
      out_nxt      = ev_item;
      out_nxt.last = cmd.last;
    end else if (cmd.emit_byte) begin
      out_nxt         = '0;
      out_nxt.kind    = K_TX;
      out_nxt.tx_byte = tx;
      out_nxt.last    = cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts            = '0;
    sts.frame_done = done_r;
    sts.len        = len_r;
    sts.plan_go    = p_go;
    sts.has_event  = ev_r;
    sts.reply      = reply_r;
    sts.dlen       = dl_r;
    sts.out_free   = out_free;
  end
endmodule
`default_nettype wire

// File: sv/servo_bus_packet_responder.sv
// top level: servo bus slave that frames, checks and answers bus packets
//
//  channel  direction  handshake        payload
//  in_      input      valid / stall    in_item_t  (bus byte or telemetry)
//  out_     output     valid / stall    out_item_t (tx byte or event)
//  cfg_     input      write enable     index, 8-bit data
//
// a byte or telemetry item completing no frame returns to idle after check
// a complete frame adds len+1 checksum reads, 1 check read and 10 field
// reads via the single frame store port, then one result per unstalled cycle
// reset is synchronous; the frame store reads as zero until written
// a stalled result holds the controller, while one waiting result does not
// block the next input transaction
`default_nettype none
`include "assert_macros.svh"
module servo_bus_packet_responder import sbpr_pkg::*; #(
  parameter int FRAME_BYTES    = FRAME_BYTES_DEF,
  parameter int MAX_READ_BYTES = MAX_READ_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata
);
  cmd_t cmd;
  sts_t sts;
  logic in_fire;

  // input transaction completes here
  assign in_fire = in_valid && !in_stall;

  // controller: check, fetch, decide, emit
  sbpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: frame store, decode, telemetry and result register
  sbpr_dp #(
    .FRAME_BYTES    (FRAME_BYTES),
    .MAX_READ_BYTES (MAX_READ_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // the block always goes busy after taking a transaction
  `SBPR_ASSERT_NEXT(a_busy_after_accept, in_fire, in_stall)
  // event results never carry a transmit byte
  `SBPR_ASSERT_NOW(a_event_no_tx, out_valid && out_data.kind != K_TX, out_data.tx_byte == 8'h00)
  // id change events only carry a legal node id
  `SBPR_ASSERT_NOW(a_id_range, out_valid && out_data.kind == K_ID, out_data.new_id != 8'h00 && out_data.new_id <= ID_MAX)
endmodule
`default_nettype wire
